// File: hw/rtl/aes128_pkg.sv
// shared types, constants and byte functions for the aes-128 block cipher unit
`default_nettype none
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [0:0] {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_index_t;

  // what travels from one round cell to the next; rkeys holds keys 0 to 10, key 0 on top
  typedef struct packed {
    logic          valid;
    logic          decrypt;
    logic [127:0]  state;
    logic [1407:0] rkeys;
  } aes128_stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // inverse s-box, found by searching the forward table
  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) begin
        r = 8'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
    return b[127 - 8*i -: 8];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aes128_key_cell.sv
// one cell of the key schedule chain: derives the next round key
`default_nettype none
module aes128_key_cell import aes128_pkg::*; #(
  parameter int unsigned Round = 1
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic [127:0] key_in,
  output logic [127:0]      key_out
);

  logic [31:0] w [4];
  logic [31:0] t;
  logic [31:0] last;
  logic [127:0] key_next;

  // rot, sub and rcon on the last word, then the running xor
  always_comb begin
    last = key_in[31:0];
    t = {SBOX[last[23:16]] ^ RCON[Round-1], SBOX[last[15:8]],
         SBOX[last[7:0]], SBOX[last[31:24]]};
    w[0] = key_in[127:96] ^ t;
    w[1] = key_in[95:64] ^ w[0];
    w[2] = key_in[63:32] ^ w[1];
    w[3] = key_in[31:0] ^ w[2];
    key_next = {w[0], w[1], w[2], w[3]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_out <= key_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aes128_round_cell.sv
// one cipher round cell: encrypt or decrypt round, handing state to the next cell
`default_nettype none
module aes128_round_cell import aes128_pkg::*; #(
  parameter int unsigned Round = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire aes128_stage_t stage_in,
  output aes128_stage_t      stage_out
);

  localparam bit Last = (Round == NumRounds);

  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [7:0]   di [16];
  logic [7:0]   dm [16];
  logic [7:0]   x2, x4, x8;
  logic [7:0]   a [4];
  logic [7:0]   a9 [4];
  logic [7:0]   ab [4];
  logic [7:0]   ad [4];
  logic [7:0]   ae [4];
  logic [127:0] ekey, dkey;
  logic [127:0] enc_res, dec_res;
  logic [127:0] state_next;

  // round keys: encrypt uses key Round, decrypt uses key NumRounds-Round
  assign ekey = stage_in.rkeys[1407 - 128*Round -: 128];
  assign dkey = stage_in.rkeys[1407 - 128*(NumRounds-Round) -: 128];

  // forward round
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[get_byte(stage_in.state, i)];
    end
    for (int i = 0; i < 16; i++) begin
      sr[i] = sb[(i + 4*(i % 4)) % 16];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mc[4*c+r] = xtime(sr[4*c+r]) ^ xtime(sr[4*c+(r+1)%4]) ^ sr[4*c+(r+1)%4]
                    ^ sr[4*c+(r+2)%4] ^ sr[4*c+(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      enc_res[127 - 8*i -: 8] = (Last ? sr[i] : mc[i]) ^ ekey[127 - 8*i -: 8];
    end
  end

  // inverse round: inv shift, inv sub, add key, inv mix unless final
  always_comb begin
    x2 = 8'h00;
    x4 = 8'h00;
    x8 = 8'h00;
    for (int i = 0; i < 16; i++) begin
      di[i] = inv_sbox(get_byte(stage_in.state, (i + 16 - 4*(i % 4)) % 16))
              ^ dkey[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = di[4*c+r];
        x2 = xtime(a[r]);
        x4 = xtime(x2);
        x8 = xtime(x4);
        a9[r] = x8 ^ a[r];
        ab[r] = x8 ^ x2 ^ a[r];
        ad[r] = x8 ^ x4 ^ a[r];
        ae[r] = x8 ^ x4 ^ x2;
      end
      for (int r = 0; r < 4; r++) begin
        dm[4*c+r] = ae[r] ^ ab[(r+1)%4] ^ ad[(r+2)%4] ^ a9[(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      dec_res[127 - 8*i -: 8] = Last ? di[i] : dm[i];
    end
  end

  assign state_next = stage_in.decrypt ? dec_res : enc_res;

  // valid bit under reset, payload plain
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_in.valid;
    end
    if (advance) begin
      stage_out.decrypt <= stage_in.decrypt;
      stage_out.state   <= state_next;
      stage_out.rkeys   <= stage_in.rkeys;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aes128_block_cipher_unit.sv
// top level of the aes-128 ecb block cipher unit
// One 128-bit block is accepted per cycle while in_ready is high and its result
// passes through eleven registers (one input cell for the initial key add and
// ten round cells, the last of which drives the output); throughput is one
// item per cycle, set by the chain of round cells, while the chain does not stall.
// The round keys are expanded from the key registers by a chain of ten key
// cells, so in_ready stays low after reset and after each key write while that
// chain settles. The whole chain stalls while the output holds an item not yet taken.
`default_nettype none
module aes128_block_cipher_unit import aes128_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_high,
  output logic [63:0]      result_low
);

  logic [63:0]   key_high, key_low;
  logic [127:0]  rk [NumRounds+1];
  logic [1407:0] rkeys_all;
  aes128_stage_t chain [NumRounds+1];
  aes128_stage_t stage0_next;
  logic          advance;
  logic [127:0]  in_block;
  logic [3:0]    key_wait;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_KEY_HIGH: key_high <= cfg_data;
        CFG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // settle count for the key cell chain after reset or a key write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      key_wait <= 4'(NumRounds);
    end else if (key_wait != 4'd0) begin
      key_wait <= key_wait - 4'd1;
    end
  end

  // key schedule chain, one cell per round key 1 to 10; key 0 comes straight from the key registers
  assign rk[0] = {key_high, key_low};
  for (genvar g = 1; g <= NumRounds; g++) begin : g_key
    aes128_key_cell #(.Round(g)) u_key (
      .clk(clk), .load(1'b1), .key_in(rk[g-1]), .key_out(rk[g])
    );
  end
  for (genvar g = 0; g <= NumRounds; g++) begin : g_pack
    assign rkeys_all[1407 - 128*g -: 128] = rk[g];
  end

  // whole chain moves when the output slot is free or being emptied
  assign advance  = !chain[NumRounds].valid || out_ready;
  assign in_ready = advance && (key_wait == 4'd0);
  assign in_block = {block_high, block_low};

  // input cell: initial key add (key 0 for encrypt, key 10 for decrypt)
  always_comb begin
    stage0_next.valid   = in_valid && in_ready;
    stage0_next.decrypt = (req_type_t'(req_type) == REQ_DECRYPT);
    stage0_next.rkeys   = rkeys_all;
    stage0_next.state   = in_block ^ (stage0_next.decrypt ? rk[NumRounds] : rk[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (advance) begin
      chain[0].valid <= stage0_next.valid;
    end
    if (advance) begin
      chain[0].decrypt <= stage0_next.decrypt;
      chain[0].state   <= stage0_next.state;
      chain[0].rkeys   <= stage0_next.rkeys;
    end
  end

  // round cells
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes128_round_cell #(.Round(g)) u_round (
      .clk(clk), .rst(rst), .advance(advance),
      .stage_in(chain[g-1]), .stage_out(chain[g])
    );
  end

  assign out_valid   = chain[NumRounds].valid;
  assign result_high = chain[NumRounds].state[127:64];
  assign result_low  = chain[NumRounds].state[63:0];

endmodule
`default_nettype wire
